>>> design/fatlb_pkg.sv
package fatlb_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int VPN_W       = 32;
  localparam int PPN_W       = 32;
  localparam int STAMP_W     = 24;
  localparam int SLOT_W      = 8;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // Item fields broadcast to every cell while a walk is in flight.
  typedef struct packed {
    logic               op;
    logic [VPN_W-1:0]   vpn;
    logic [PPN_W-1:0]   new_ppn;
    logic [STAMP_W-1:0] cycle;
  } item_t;

  // Running result handed from one cell to the next.
  typedef struct packed {
    logic               found;
    logic               have_inv;
    logic               have_best;
    logic [STAMP_W-1:0] best_stamp;
    logic [SLOT_W-1:0]  idx;
    logic [PPN_W-1:0]   ppn;
  } acc_t;

  // Update broadcast to the cells when an item completes.
  typedef struct packed {
    logic               en;
    logic               fill;
    logic [SLOT_W-1:0]  idx;
    logic [VPN_W-1:0]   tag;
    logic [PPN_W-1:0]   ppn;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

endpackage

>>> design/fatlb_req_if.sv
interface fatlb_req_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [fatlb_pkg::VPN_W-1:0]    vpn;
  logic [fatlb_pkg::PPN_W-1:0]    new_ppn;
  logic [fatlb_pkg::STAMP_W-1:0]  cycle;

  modport source (output valid, output op, output vpn, output new_ppn, output cycle,
                  input ready);
  modport sink (input valid, input op, input vpn, input new_ppn, input cycle,
                output ready);
endinterface

>>> design/fatlb_rsp_if.sv
interface fatlb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [fatlb_pkg::PPN_W-1:0]   ppn;
  logic [fatlb_pkg::SLOT_W-1:0]  slot;

  modport source (output valid, output hit, output ppn, output slot, input ready);
  modport sink (input valid, input hit, input ppn, input slot, output ready);
endinterface

>>> design/fatlb_cell.sv
module fatlb_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  fatlb_pkg::item_t item,
  input  fatlb_pkg::wr_t   wr,
  input  logic             tok_in,
  input  fatlb_pkg::acc_t  acc_in,
  output logic             tok_out,
  output fatlb_pkg::acc_t  acc_out
);

  localparam logic [fatlb_pkg::SLOT_W-1:0] MY_IDX = fatlb_pkg::SLOT_W'(CELL_IDX);

  logic                             valid;
  logic [fatlb_pkg::VPN_W-1:0]      tag;
  logic [fatlb_pkg::PPN_W-1:0]      ppn;
  logic [fatlb_pkg::STAMP_W-1:0]    stamp;
  fatlb_pkg::acc_t                  acc_next;
  logic                             wr_hit;

  assign wr_hit = wr.en && (wr.idx == MY_IDX);

  always_comb begin
    acc_next = acc_in;
    if (item.op == fatlb_pkg::OP_LOOKUP) begin
      if (!acc_in.found && valid && (tag == item.vpn)) begin
        acc_next.found = 1'b1;
        acc_next.idx   = MY_IDX;
        acc_next.ppn   = ppn;
      end
    end else begin
      // Once an empty entry is seen it is the victim; otherwise keep the oldest.
      if (!acc_in.have_inv) begin
        if (!valid) begin
          acc_next.have_inv = 1'b1;
          acc_next.idx      = MY_IDX;
        end else if (!acc_in.have_best || (stamp < acc_in.best_stamp)) begin
          acc_next.have_best  = 1'b1;
          acc_next.best_stamp = stamp;
          acc_next.idx        = MY_IDX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      stamp   <= '0;
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (wr_hit) begin
        stamp <= wr.stamp;
        if (wr.fill) begin
          valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit && wr.fill) begin
      tag <= wr.tag;
      ppn <= wr.ppn;
    end
    if (tok_in) begin
      acc_out <= acc_next;
    end
  end

endmodule

>>> design/fully_assoc_tlb_lru_unit.sv
// The accepted request is registered, then the search token walks the row of cells one entry
// per cycle; the chosen entry is updated as the result is loaded, once the output register is
// free. A new request is accepted only after the current item has finished.
// A request can be accepted while the previous response still waits to be taken.
// Reset: synchronous; all entries become invalid with zero stamps, no result pending.
module fully_assoc_tlb_lru_unit #(
  parameter int ENTRIES = fatlb_pkg::ENTRIES_DEF
) (
  input logic           clk,
  input logic           rst,
  fatlb_req_if.sink     req,
  fatlb_rsp_if.source   rsp
);

  fatlb_pkg::state_t              state;
  fatlb_pkg::state_t              state_next;
  fatlb_pkg::item_t               item;
  fatlb_pkg::wr_t                 wr;
  fatlb_pkg::acc_t                acc_chain [ENTRIES+1];
  logic [ENTRIES:0]               tok_chain;
  logic                           start;
  logic                           accept;
  logic                           finish;
  logic                           out_free;
  logic                           out_valid;
  logic                           out_hit;
  logic [fatlb_pkg::PPN_W-1:0]    out_ppn;
  logic [fatlb_pkg::SLOT_W-1:0]   out_slot;
  fatlb_pkg::acc_t                res;

  assign req.ready = (state == fatlb_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign res       = acc_chain[ENTRIES];

  assign acc_chain[0] = '0;
  assign tok_chain[0] = start;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    fatlb_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .item    (item),
      .wr      (wr),
      .tok_in  (tok_chain[i]),
      .acc_in  (acc_chain[i]),
      .tok_out (tok_chain[i+1]),
      .acc_out (acc_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fatlb_pkg::ST_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op      <= req.op;
      item.vpn     <= req.vpn;
      item.new_ppn <= req.new_ppn;
      item.cycle   <= req.cycle;
    end
  end

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    case (state)
      fatlb_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = fatlb_pkg::ST_WALK;
        end
      end
      fatlb_pkg::ST_WALK: begin
        if (tok_chain[ENTRIES]) begin
          if (out_free) begin
            finish     = 1'b1;
            state_next = fatlb_pkg::ST_IDLE;
          end else begin
            state_next = fatlb_pkg::ST_DONE;
          end
        end
      end
      fatlb_pkg::ST_DONE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = fatlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fatlb_pkg::ST_IDLE;
      end
    endcase
  end

  // A lookup hit refreshes the stamp; a fill rewrites the whole victim entry.
  always_comb begin
    wr.en    = finish && ((item.op == fatlb_pkg::OP_FILL) || res.found);
    wr.fill  = (item.op == fatlb_pkg::OP_FILL);
    wr.idx   = res.idx;
    wr.tag   = item.vpn;
    wr.ppn   = item.new_ppn;
    wr.stamp = item.cycle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (item.op == fatlb_pkg::OP_FILL) begin
        out_hit  <= 1'b0;
        out_ppn  <= item.new_ppn;
        out_slot <= res.idx;
      end else if (res.found) begin
        out_hit  <= 1'b1;
        out_ppn  <= res.ppn;
        out_slot <= res.idx;
      end else begin
        out_hit  <= 1'b0;
        out_ppn  <= '0;
        out_slot <= '0;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.hit   = out_hit;
  assign rsp.ppn   = out_ppn;
  assign rsp.slot  = out_slot;

  a_tok_single : assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_chain))
    else $error("more than one search token in the cell row");

  a_start_walk : assert property (@(posedge clk) disable iff (rst)
    accept |=> tok_chain[0] && (state == fatlb_pkg::ST_WALK))
    else $error("accepted beat did not launch a search");

  a_wr_on_finish : assert property (@(posedge clk) disable iff (rst)
    wr.en |-> out_free && (state != fatlb_pkg::ST_IDLE))
    else $error("entry update outside of result hand-off");

  a_rsp_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(tok_chain[ENTRIES]) || $past(state == fatlb_pkg::ST_DONE))
    else $error("response raised without a completed search");

endmodule

>>> sim/fully_assoc_tlb_lru_unit_test.sv
module fully_assoc_tlb_lru_unit_test;
  import fatlb_pkg::*;

  localparam int N_ENTRIES = ENTRIES_DEF;
  localparam logic [STAMP_W-1:0] STAMP_MAX = 24'd9999999;
  localparam int RANDOM_ITEMS = 1050;
  localparam int POOL_SIZE = 20;
  localparam int HOLD_AFTER = 300;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = N_ENTRIES + 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic              hit;
    logic [PPN_W-1:0]  ppn;
    logic [SLOT_W-1:0] slot;
  } xlat_t;

  // Mirror of the translation entries; it predicts one response per request beat.
  class tlb_mirror;
    bit                live[N_ENTRIES];
    bit [VPN_W-1:0]    tag[N_ENTRIES];
    bit [PPN_W-1:0]    page[N_ENTRIES];
    bit [STAMP_W-1:0]  stamp[N_ENTRIES];
    xlat_t             awaited[$];
    int                errors;

    function new();
      errors = 0;
      foreach (live[i]) begin
        live[i] = 1'b0;
        tag[i] = '0;
        page[i] = '0;
        stamp[i] = '0;
      end
    endfunction

    // First free entry, else the oldest stamp with the lowest index on ties.
    function int pick_victim();
      int victim;
      bit [STAMP_W-1:0] oldest;
      victim = -1;
      for (int i = 0; i < N_ENTRIES && victim < 0; i++) begin
        if (!live[i]) victim = i;
      end
      if (victim < 0) begin
        victim = 0;
        oldest = stamp[0];
        for (int i = 1; i < N_ENTRIES; i++) begin
          if (stamp[i] < oldest) begin
            oldest = stamp[i];
            victim = i;
          end
        end
      end
      return victim;
    endfunction

    function void note_request(logic op, logic [VPN_W-1:0] vpn, logic [PPN_W-1:0] new_ppn,
                               logic [STAMP_W-1:0] cyc);
      xlat_t r;
      int v;
      bit found;
      r = '0;
      found = 1'b0;
      if (op == OP_LOOKUP) begin
        for (int i = 0; i < N_ENTRIES && !found; i++) begin
          if (live[i] && tag[i] == vpn) begin
            found = 1'b1;
            stamp[i] = cyc;
            r.hit = 1'b1;
            r.ppn = page[i];
            r.slot = SLOT_W'(i);
          end
        end
      end else begin
        v = pick_victim();
        live[v] = 1'b1;
        tag[v] = vpn;
        page[v] = new_ppn;
        stamp[v] = cyc;
        r.ppn = new_ppn;
        r.slot = SLOT_W'(v);
      end
      awaited.push_back(r);
    endfunction

    function void check_response(logic hit, logic [PPN_W-1:0] ppn, logic [SLOT_W-1:0] slot);
      xlat_t got;
      xlat_t want;
      got.hit = hit;
      got.ppn = ppn;
      got.slot = slot;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("response beat with nothing pending: hit=%0b ppn=%h slot=%0d",
                   hit, ppn, slot);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: expected hit=%0b ppn=%h slot=%0d, got hit=%0b ppn=%h slot=%0d",
                   want.hit, want.ppn, want.slot, got.hit, got.ppn, got.slot);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int accepted_reqs;
  tlb_mirror mirror = new();

  fatlb_req_if req_bus();
  fatlb_rsp_if rsp_bus();

  fully_assoc_tlb_lru_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one request beat and returns at the edge where it is taken.
  task automatic drive_item(input logic op, input logic [VPN_W-1:0] vpn,
                            input logic [PPN_W-1:0] new_ppn, input logic [STAMP_W-1:0] cyc);
    req_bus.valid <= 1'b1;
    req_bus.op <= op;
    req_bus.vpn <= vpn;
    req_bus.new_ppn <= new_ppn;
    req_bus.cycle <= cyc;
    do @(posedge clk); while (!req_bus.ready);
    mirror.note_request(op, vpn, new_ppn, cyc);
    accepted_reqs++;
  endtask

  initial begin
    logic [VPN_W-1:0] vpn_pool[POOL_SIZE];
    int made;
    int burst;
    int gap;
    int clock_now;
    logic op;
    logic [VPN_W-1:0] vpn;
    logic [STAMP_W-1:0] cyc;

    accepted_reqs = 0;
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.op <= OP_LOOKUP;
    req_bus.vpn <= '0;
    req_bus.new_ppn <= '0;
    req_bus.cycle <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Misses on an empty buffer, then extremes of every field.
    drive_item(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 24'd0);
    drive_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, STAMP_MAX);
    drive_item(OP_FILL, 32'h0000_0000, 32'hFFFF_FFFF, 24'd0);
    drive_item(OP_FILL, 32'hFFFF_FFFF, 32'h0000_0000, STAMP_MAX);
    // Duplicate tag: later lookups must keep hitting the lower entry.
    drive_item(OP_FILL, 32'h0000_0000, 32'h1234_5678, 24'd5);
    drive_item(OP_LOOKUP, 32'h0000_0000, 32'h0, 24'd100);
    drive_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 24'd0);
    for (int i = 3; i < N_ENTRIES; i++)
      drive_item(OP_FILL, 32'hA5A5_0000 | i, 32'h5A5A_5A5A ^ i, 24'd50);
    // Buffer is full now, so fills evict the oldest stamp, lowest index on ties.
    drive_item(OP_FILL, 32'h5A5A_5A5A, 32'hC0DE_0001, 24'd7);
    drive_item(OP_FILL, 32'hDEAD_BEEF, 32'hC0DE_0002, 24'd7);
    drive_item(OP_FILL, 32'h8000_0001, 32'hC0DE_0003, 24'd9);
    drive_item(OP_LOOKUP, 32'h0000_0000, 32'h0, 24'd200);
    drive_item(OP_LOOKUP, 32'h7777_7777, 32'h0, 24'd201);

    foreach (vpn_pool[i]) vpn_pool[i] = $urandom;
    vpn_pool[0] = 32'h0000_0000;
    vpn_pool[1] = 32'hFFFF_FFFF;
    clock_now = $urandom_range(0, int'(STAMP_MAX));

    made = 0;
    while (made < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && made < RANDOM_ITEMS; k++) begin
        // Stamps mostly advance like a real cycle count, with repeats for ties.
        clock_now = clock_now + $urandom_range(0, 40);
        if (clock_now > int'(STAMP_MAX)) clock_now = $urandom_range(0, 1000);
        if ($urandom_range(0, 9) == 0) cyc = STAMP_W'($urandom_range(0, int'(STAMP_MAX)));
        else cyc = clock_now[STAMP_W-1:0];
        op = ($urandom_range(0, 99) < 45) ? OP_FILL : OP_LOOKUP;
        if ($urandom_range(0, 9) < 8) vpn = vpn_pool[$urandom_range(0, POOL_SIZE - 1)];
        else vpn = $urandom;
        if ($urandom_range(0, 29) == 0) vpn_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
        drive_item(op, vpn, $urandom, cyc);
        made++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_bus.valid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("fully_assoc_tlb_lru_unit_test passed");
    end else begin
      $display("fully_assoc_tlb_lru_unit_test failed");
    end
    $finish;
  end

  // Response side: checks each beat and drives ready in runs of random length.
  initial begin
    int run_left;
    bit level;
    bit held;
    run_left = 0;
    level = 1'b0;
    held = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready)
        mirror.check_response(rsp_bus.hit, rsp_bus.ppn, rsp_bus.slot);
      // One long hold-off lets the block back up and stall its request side.
      if (!held && accepted_reqs >= HOLD_AFTER) begin
        held = 1'b1;
        level = 1'b0;
        run_left = LONG_HOLD;
      end else if (run_left == 0) begin
        level = ($urandom_range(0, 3) != 0);
        run_left = level ? $urandom_range(1, 120) : $urandom_range(1, 15);
      end
      run_left--;
      rsp_bus.ready <= level;
    end
  end

  initial begin
    int cycles_seen;
    cycles_seen = 0;
    while (cycles_seen < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_seen++;
    end
    $display("fully_assoc_tlb_lru_unit_test failed");
    $finish;
  end

endmodule
